// ----- rtl/core/czc_pkg.sv -----
// czc_pkg: register map, configuration record, bounds type and the bounds
// function shared by the core zone centroid filter modules
// depends on nothing
`timescale 1ns / 1ps

package czc_pkg;

  // fixed field widths
  localparam int COORD_W     = 13;
  localparam int SIDE_W      = 14;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 14;
  localparam int REPORT_W    = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CORE_MARGIN   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_ORIGIN_X = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_ORIGIN_Y = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_WIDTH    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TILE_HEIGHT   = 3'd6;

  // reset values
  localparam logic [SIDE_W-1:0] MAX_IMAGE_SIDE  = 14'd8192;
  localparam logic [SIDE_W-1:0] TILE_SIDE_RESET = 14'd1024;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [COORD_W-1:0] core_margin;
    logic [SIDE_W-1:0]  image_width;
    logic [SIDE_W-1:0]  image_height;
    logic [COORD_W-1:0] tile_origin_x;
    logic [COORD_W-1:0] tile_origin_y;
    logic [SIDE_W-1:0]  tile_width;
    logic [SIDE_W-1:0]  tile_height;
  } czc_cfg_t;

  // per particle status carried with the sums
  typedef struct packed {
    logic empty;
    logic ovf;
  } czc_flags_t;

  // core interval [lo, hi) on one axis
  typedef struct packed {
    logic [SIDE_W-1:0] lo;
    logic [SIDE_W-1:0] hi;
  } czc_bounds_t;

  function automatic czc_bounds_t axis_bounds(
    input logic [COORD_W-1:0] origin,
    input logic [SIDE_W-1:0]  extent,
    input logic [SIDE_W-1:0]  full,
    input logic [COORD_W-1:0] margin
  );
    czc_bounds_t        b;
    logic [COORD_W-1:0] lo_raw;
    logic [SIDE_W:0]    far_end;
    logic [SIDE_W:0]    hi_raw;
    logic               touch_far;
    logic               no_room;
    lo_raw    = (origin == '0) ? '0 : margin;
    far_end   = {2'b00, origin} + {1'b0, extent};
    touch_far = (far_end >= {1'b0, full});
    hi_raw    = touch_far ? {1'b0, extent} : ({1'b0, extent} - {2'b00, margin});
    no_room   = ($signed(hi_raw) <= $signed({2'b00, lo_raw}));
    if (no_room) begin
      b.lo = '0;
      b.hi = extent;
    end else begin
      b.lo = {1'b0, lo_raw};
      b.hi = hi_raw[SIDE_W-1:0];
    end
    return b;
  endfunction

endpackage

// ----- rtl/core/czc_point_if.sv -----
// czc_point_if: valid/ready channel carrying one contour point
// depends on czc_pkg
`timescale 1ns / 1ps

interface czc_point_if;
  logic                        valid;
  logic                        ready;
  logic [czc_pkg::COORD_W-1:0] point_x;
  logic [czc_pkg::COORD_W-1:0] point_y;
  logic                        last_point;
  logic                        no_points;

  modport source(output valid, point_x, point_y, last_point, no_points, input ready);
  modport sink(input valid, point_x, point_y, last_point, no_points, output ready);
endinterface

// ----- rtl/core/czc_result_if.sv -----
// czc_result_if: valid/ready channel carrying one particle decision
// depends on czc_pkg
`timescale 1ns / 1ps

interface czc_result_if;
  logic                         valid;
  logic                         ready;
  logic                         keep;
  logic [czc_pkg::REPORT_W-1:0] kept_count;
  logic [czc_pkg::REPORT_W-1:0] discarded_count;
  logic                         overflow;

  modport source(output valid, keep, kept_count, discarded_count, overflow, input ready);
  modport sink(input valid, keep, kept_count, discarded_count, overflow, output ready);
endinterface

// ----- rtl/core/czc_front.sv -----
// czc_front: accepts contour points, accumulates sums and point count and
// pushes one record per particle into the queue
// depends on czc_pkg, czc_point_if
`timescale 1ns / 1ps

module czc_front #(
  parameter int MAX_POINTS = 4096
) (
  input  logic              clk,
  input  logic              rst,
  czc_point_if.sink         points,
  input  logic              q_full,
  output logic              q_push,
  output logic [2*(czc_pkg::COORD_W+$clog2(MAX_POINTS+1))+$clog2(MAX_POINTS+1)+
                $bits(czc_pkg::czc_flags_t)-1:0] q_data
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = czc_pkg::COORD_W + CNT_W;

  logic [SUM_W-1:0] sum_x, sum_x_next;
  logic [SUM_W-1:0] sum_y, sum_y_next;
  logic [CNT_W-1:0] point_count, point_count_next;
  logic             too_many_points, too_many_points_next;
  logic             accept;
  czc_pkg::czc_flags_t flags;

  // room for the point in the stream
  assign points.ready = !q_full;
  assign accept       = points.valid && points.ready;
  assign q_push       = accept && (points.no_points || points.last_point);

  // accumulate unless the contour has reached its point limit
  always_comb begin
    sum_x_next           = sum_x;
    sum_y_next           = sum_y;
    point_count_next     = point_count;
    too_many_points_next = too_many_points;
    if (point_count < CNT_W'(MAX_POINTS)) begin
      sum_x_next       = sum_x + SUM_W'(points.point_x);
      sum_y_next       = sum_y + SUM_W'(points.point_y);
      point_count_next = point_count + 1'b1;
    end else begin
      too_many_points_next = 1'b1;
    end
  end

  // particle record for the back end
  always_comb begin
    if (points.no_points) begin
      flags.empty = 1'b1;
      flags.ovf   = 1'b0;
      q_data      = {flags, {CNT_W{1'b0}}, {SUM_W{1'b0}}, {SUM_W{1'b0}}};
    end else begin
      flags.empty = 1'b0;
      flags.ovf   = too_many_points_next;
      q_data      = {flags, point_count_next, sum_y_next, sum_x_next};
    end
  end

  // accumulator, restarted at every particle boundary
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x           <= '0;
      sum_y           <= '0;
      point_count     <= '0;
      too_many_points <= 1'b0;
    end else if (accept) begin
      if (q_push) begin
        sum_x           <= '0;
        sum_y           <= '0;
        point_count     <= '0;
        too_many_points <= 1'b0;
      end else begin
        sum_x           <= sum_x_next;
        sum_y           <= sum_y_next;
        point_count     <= point_count_next;
        too_many_points <= too_many_points_next;
      end
    end
  end

endmodule

// ----- rtl/core/czc_queue.sv -----
// czc_queue: small first-in first-out buffer of particle records between
// the front and the back
// depends on nothing
`timescale 1ns / 1ps

module czc_queue #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full     = (fill == CNT_W'(DEPTH));
  assign valid    = (fill != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign pop_data = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/czc_back.sv -----
// czc_back: core zone test by cross-multiplication, kept and discarded
// counters and the result output register
// depends on czc_pkg, czc_result_if
`timescale 1ns / 1ps

module czc_back #(
  parameter int MAX_POINTS = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  czc_pkg::czc_cfg_t cfg,
  input  logic              cfg_clear,
  input  logic              q_valid,
  input  logic [2*(czc_pkg::COORD_W+$clog2(MAX_POINTS+1))+$clog2(MAX_POINTS+1)+
                $bits(czc_pkg::czc_flags_t)-1:0] q_data,
  output logic              q_pop,
  czc_result_if.source      results
);

  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = czc_pkg::COORD_W + CNT_W;
  localparam int PROD_W = czc_pkg::SIDE_W + CNT_W;

  czc_pkg::czc_bounds_t x_bnd;
  czc_pkg::czc_bounds_t y_bnd;

  czc_pkg::czc_flags_t q_flags;
  logic [CNT_W-1:0]    q_count;
  logic [SUM_W-1:0]    q_sum_x;
  logic [SUM_W-1:0]    q_sum_y;

  logic                a_valid;
  czc_pkg::czc_flags_t a_flags;
  logic [SUM_W-1:0]    a_sum_x;
  logic [SUM_W-1:0]    a_sum_y;
  logic [PROD_W-1:0]   a_x_lo;
  logic [PROD_W-1:0]   a_x_hi;
  logic [PROD_W-1:0]   a_y_lo;
  logic [PROD_W-1:0]   a_y_hi;

  logic                  out_valid;
  logic                  out_keep;
  logic                  out_ovf;
  logic [COUNT_BITS-1:0] out_kept;
  logic [COUNT_BITS-1:0] out_disc;

  logic [COUNT_BITS-1:0] kept_total, kept_total_next;
  logic [COUNT_BITS-1:0] discarded_total, discarded_total_next;

  logic advance_out;
  logic load_a;
  logic inside_x;
  logic inside_y;
  logic keep_now;

  assign {q_flags, q_count, q_sum_y, q_sum_x} = q_data;

  // core intervals are registered from the configuration registers
  always_ff @(posedge clk) begin
    x_bnd <= czc_pkg::axis_bounds(cfg.tile_origin_x, cfg.tile_width,
                                  cfg.image_width, cfg.core_margin);
    y_bnd <= czc_pkg::axis_bounds(cfg.tile_origin_y, cfg.tile_height,
                                  cfg.image_height, cfg.core_margin);
  end

  // stall control: the output register frees the pipeline when it is taken
  assign advance_out = !out_valid || results.ready;
  assign load_a      = !a_valid || advance_out;
  assign q_pop       = q_valid && load_a;

  // stage a: interval bounds scaled by the point count
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (load_a) begin
      a_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_flags <= q_flags;
      a_sum_x <= q_sum_x;
      a_sum_y <= q_sum_y;
      a_x_lo  <= PROD_W'(x_bnd.lo) * PROD_W'(q_count);
      a_x_hi  <= PROD_W'(x_bnd.hi) * PROD_W'(q_count);
      a_y_lo  <= PROD_W'(y_bnd.lo) * PROD_W'(q_count);
      a_y_hi  <= PROD_W'(y_bnd.hi) * PROD_W'(q_count);
    end
  end

  // stage b: exact centroid test and saturating counters
  assign inside_x = (PROD_W'(a_sum_x) >= a_x_lo) && (PROD_W'(a_sum_x) < a_x_hi);
  assign inside_y = (PROD_W'(a_sum_y) >= a_y_lo) && (PROD_W'(a_sum_y) < a_y_hi);
  assign keep_now = a_flags.empty || (inside_x && inside_y);

  always_comb begin
    kept_total_next      = kept_total;
    discarded_total_next = discarded_total;
    if (keep_now) begin
      if (kept_total != '1) begin
        kept_total_next = kept_total + 1'b1;
      end
    end else begin
      if (discarded_total != '1) begin
        discarded_total_next = discarded_total + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      kept_total      <= '0;
      discarded_total <= '0;
    end else if (a_valid && advance_out) begin
      kept_total      <= kept_total_next;
      discarded_total <= discarded_total_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance_out) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && advance_out) begin
      out_keep <= keep_now;
      out_ovf  <= a_flags.ovf;
      out_kept <= kept_total_next;
      out_disc <= discarded_total_next;
    end
  end

  assign results.valid           = out_valid;
  assign results.keep            = out_keep;
  assign results.overflow        = out_ovf;
  assign results.kept_count      = czc_pkg::REPORT_W'(out_kept);
  assign results.discarded_count = czc_pkg::REPORT_W'(out_disc);

endmodule

// ----- rtl/core/core_zone_centroid_filter.sv -----
// core_zone_centroid_filter: top level with configuration registers, front,
// record queue and back
// depends on czc_pkg, czc_point_if, czc_result_if, czc_front, czc_queue, czc_back
`timescale 1ns / 1ps

// Takes one contour point per cycle and gives one transaction per particle,
// at its last point or at a no-points item. A particle's record is written
// into the queue on the accepting edge, then moves through the count
// multipliers into stage a and through the compare and counter stage into
// the output register. The front accumulates sums in one add per point; a
// four-entry queue lets points keep flowing while a result waits to be
// taken, and the input stalls only when that queue is full. Any write to a
// listed register clears the kept and discarded counters; the core interval
// is recomputed into its own register from the written configuration.
module core_zone_centroid_filter #(
  parameter int MAX_POINTS = 4096,
  parameter int COUNT_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  czc_point_if.sink                        points,
  czc_result_if.source                     results,
  input  logic                             cfg_write_en,
  input  logic [czc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [czc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int SUM_W = czc_pkg::COORD_W + CNT_W;
  localparam int REC_W = 2 * SUM_W + CNT_W + $bits(czc_pkg::czc_flags_t);

  czc_pkg::czc_cfg_t cfg;
  logic              cfg_clear;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_valid;
  logic [REC_W-1:0] q_in;
  logic [REC_W-1:0] q_out;

  // configuration registers
  assign cfg_clear = cfg_write_en && (cfg_index <= czc_pkg::REG_TILE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.core_margin   <= '0;
      cfg.image_width   <= czc_pkg::MAX_IMAGE_SIDE;
      cfg.image_height  <= czc_pkg::MAX_IMAGE_SIDE;
      cfg.tile_origin_x <= '0;
      cfg.tile_origin_y <= '0;
      cfg.tile_width    <= czc_pkg::TILE_SIDE_RESET;
      cfg.tile_height   <= czc_pkg::TILE_SIDE_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        czc_pkg::REG_CORE_MARGIN:   cfg.core_margin   <= cfg_data[czc_pkg::COORD_W-1:0];
        czc_pkg::REG_IMAGE_WIDTH:   cfg.image_width   <= cfg_data[czc_pkg::SIDE_W-1:0];
        czc_pkg::REG_IMAGE_HEIGHT:  cfg.image_height  <= cfg_data[czc_pkg::SIDE_W-1:0];
        czc_pkg::REG_TILE_ORIGIN_X: cfg.tile_origin_x <= cfg_data[czc_pkg::COORD_W-1:0];
        czc_pkg::REG_TILE_ORIGIN_Y: cfg.tile_origin_y <= cfg_data[czc_pkg::COORD_W-1:0];
        czc_pkg::REG_TILE_WIDTH:    cfg.tile_width    <= cfg_data[czc_pkg::SIDE_W-1:0];
        czc_pkg::REG_TILE_HEIGHT:   cfg.tile_height   <= cfg_data[czc_pkg::SIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // point accumulation
  czc_front #(
    .MAX_POINTS(MAX_POINTS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .points (points),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  // particle records in flight
  czc_queue #(
    .WIDTH(REC_W),
    .DEPTH(czc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (q_full),
    .valid     (q_valid)
  );

  // decision and counters
  czc_back #(
    .MAX_POINTS(MAX_POINTS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_clear (cfg_clear),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .results   (results)
  );

  // no result survives a reset
  a_reset_clears_output: assert property (@(posedge clk) rst |=> !results.valid)
    else $error("result valid right after reset");

  // the back end never takes a record from an empty queue
  a_pop_needs_record: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("record popped from empty queue");

  // the front end never offers a record the queue cannot hold
  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("record pushed into full queue");

  // a shown decision is always reflected in its own counter
  a_keep_counted: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.keep && (COUNT_BITS <= czc_pkg::REPORT_W)
      |-> results.kept_count != '0)
    else $error("kept particle with zero kept count");

  a_discard_counted: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.keep && (COUNT_BITS <= czc_pkg::REPORT_W)
      |-> results.discarded_count != '0)
    else $error("discarded particle with zero discarded count");

endmodule

// ----- dv/tb_core_zone_centroid_filter.sv -----
// tb_core_zone_centroid_filter: self-checking testbench for the core zone centroid filter
// drives contour points with random gaps and back-pressure, predicts each particle decision
// depends on czc_pkg, czc_point_if, czc_result_if, core_zone_centroid_filter
`timescale 1ns / 1ps

module tb_core_zone_centroid_filter;

  localparam int MAX_POINTS        = 4096;
  localparam int COUNT_BITS        = 16;
  localparam int CYCLE_LIMIT       = 100000;
  localparam int DRAIN_CYCLES      = 8;
  localparam int HOLD_CYCLES       = 200;
  localparam int SETTINGS_RANDOM   = 8;
  localparam int ITEMS_PER_SETTING = 140;
  localparam int COORD_MAX         = 8191;

  localparam int COORD_W     = czc_pkg::COORD_W;
  localparam int SIDE_W      = czc_pkg::SIDE_W;
  localparam int CFG_INDEX_W = czc_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = czc_pkg::CFG_DATA_W;
  localparam int REPORT_W    = czc_pkg::REPORT_W;

  // index past the end of the register map, must be ignored
  localparam logic [CFG_INDEX_W-1:0] REG_UNLISTED = 3'd7;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               last_point;
    logic               no_points;
  } point_t;

  typedef struct packed {
    logic                keep;
    logic [REPORT_W-1:0] kept_count;
    logic [REPORT_W-1:0] discarded_count;
    logic                overflow;
  } decision_t;

  typedef enum logic [1:0] {ROW_POINT, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    point_t                p;
    logic [CFG_INDEX_W-1:0] index;
    int                    value;
    bit                    typed;
    decision_t             want;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  czc_point_if  points();
  czc_result_if results();

  core_zone_centroid_filter #(
    .MAX_POINTS(MAX_POINTS),
    .COUNT_BITS(COUNT_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .points       (points),
    .results      (results),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // predictor state
  czc_pkg::czc_cfg_t   tile_cfg;
  logic [24:0]         acc_x;
  logic [24:0]         acc_y;
  logic [12:0]         point_count;
  logic                too_many_points;
  logic [REPORT_W-1:0] kept_total;
  logic [REPORT_W-1:0] discarded_total;

  decision_t decisions_due[$];
  row_t      stimulus_rows[$];
  int        error_count;
  int        cycle_count;

  // sender and receiver control
  bit        sender_gaps;
  bit        receiver_stalls;
  bit        hold_request;
  int        burst_left;
  bit        typed_row;
  decision_t typed_want;

  // clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic [REPORT_W-1:0] sat_inc(input logic [REPORT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic void clear_contour();
    acc_x           = '0;
    acc_y           = '0;
    point_count     = '0;
    too_many_points = 1'b0;
  endfunction

  // exact test of sum / n inside [lo, hi) by cross-multiplying
  function automatic bit centroid_in_core(input longint origin, input longint extent,
                                          input longint full, input longint sum,
                                          input longint n);
    longint lo;
    longint hi;
    longint margin;
    margin = longint'(tile_cfg.core_margin);
    lo = (origin == 0) ? 0 : margin;
    hi = (origin + extent >= full) ? extent : extent - margin;
    if (hi <= lo) begin
      lo = 0;
      hi = extent;
    end
    return (sum >= lo * n) && (sum < hi * n);
  endfunction

  // advance the particle state by one point, returns 1 when a decision is due
  function automatic bit step_particle(input point_t p, output decision_t d);
    logic keep;
    logic ovf;
    d = '0;
    if (p.no_points) begin
      clear_contour();
      kept_total = sat_inc(kept_total);
      keep = 1'b1;
      ovf  = 1'b0;
    end else begin
      if (point_count < MAX_POINTS) begin
        acc_x       = acc_x + p.x;
        acc_y       = acc_y + p.y;
        point_count = point_count + 1'b1;
      end else begin
        too_many_points = 1'b1;
      end
      if (!p.last_point) return 1'b0;
      keep = centroid_in_core(longint'(tile_cfg.tile_origin_x),
                              longint'(tile_cfg.tile_width),
                              longint'(tile_cfg.image_width),
                              longint'(acc_x), longint'(point_count)) &&
             centroid_in_core(longint'(tile_cfg.tile_origin_y),
                              longint'(tile_cfg.tile_height),
                              longint'(tile_cfg.image_height),
                              longint'(acc_y), longint'(point_count));
      ovf = too_many_points;
      if (keep) kept_total = sat_inc(kept_total);
      else discarded_total = sat_inc(discarded_total);
      clear_contour();
    end
    d.keep            = keep;
    d.kept_count      = kept_total;
    d.discarded_count = discarded_total;
    d.overflow        = ovf;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic check_field(input string name, input logic [REPORT_W-1:0] expv,
                             input logic [REPORT_W-1:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
      error_count++;
    end
  endtask

  // result check first, then prediction of the point taken on the same edge
  always @(posedge clk) begin : scoreboard
    decision_t got;
    decision_t want;
    point_t    p;
    if (!rst) begin
      if (results.valid === 1'b1 && results.ready) begin
        got.keep            = results.keep;
        got.kept_count      = results.kept_count;
        got.discarded_count = results.discarded_count;
        got.overflow        = results.overflow;
        if (decisions_due.size() == 0) begin
          $error("decision transaction with no particle pending");
          error_count++;
        end else begin
          want = decisions_due.pop_front();
          check_field("keep", REPORT_W'(want.keep), REPORT_W'(got.keep));
          check_field("kept_count", want.kept_count, got.kept_count);
          check_field("discarded_count", want.discarded_count, got.discarded_count);
          check_field("overflow", REPORT_W'(want.overflow), REPORT_W'(got.overflow));
        end
      end
      if (points.valid && points.ready) begin
        p.x          = points.point_x;
        p.y          = points.point_y;
        p.last_point = points.last_point;
        p.no_points  = points.no_points;
        if (step_particle(p, want)) begin
          decisions_due.insert(decisions_due.size(), typed_row ? typed_want : want);
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  initial begin : result_taker
    int   run_left;
    int   stall_left;
    int   hold_left;
    logic take;
    results.ready = 1'b0;
    run_left      = 0;
    stall_left    = 0;
    hold_left     = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else if (!receiver_stalls) begin
        take = 1'b1;
      end else begin
        if (run_left == 0 && stall_left == 0) begin
          // now and then a clean stretch, otherwise short runs broken by stalls
          if ($urandom_range(0, 4) == 0) begin
            run_left   = $urandom_range(30, 120);
            stall_left = 0;
          end else begin
            run_left   = $urandom_range(0, 5);
            stall_left = $urandom_range(1, 4);
          end
        end
        if (run_left > 0) begin
          run_left--;
          take = 1'b1;
        end else begin
          stall_left--;
          take = 1'b0;
        end
      end
      results.ready <= take;
    end
  end

  // ---------------------------------------------------------------- sender

  function automatic logic [COORD_W-1:0] clip_coord(input int v);
    if (v < 0) return '0;
    if (v > COORD_MAX) return COORD_W'(COORD_MAX);
    return COORD_W'(v);
  endfunction

  function automatic point_t rand_point();
    point_t p;
    p.x          = COORD_W'($urandom_range(0, COORD_MAX));
    p.y          = COORD_W'($urandom_range(0, COORD_MAX));
    p.last_point = 1'b0;
    p.no_points  = 1'b0;
    return p;
  endfunction

  // offer one point in bursts with random gaps, returns on the accepting edge
  task automatic offer_point(input point_t p, input bit typed, input decision_t want);
    int gap;
    @(negedge clk);
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) begin
        points.valid <= 1'b0;
        @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    points.valid      <= 1'b1;
    points.point_x    <= p.x;
    points.point_y    <= p.y;
    points.last_point <= p.last_point;
    points.no_points  <= p.no_points;
    typed_row  = typed;
    typed_want = want;
    @(posedge clk);
    while (!points.ready) @(posedge clk);
  endtask

  // stop sending, wait out every pending decision and the pipeline
  task automatic drain_results();
    @(negedge clk);
    points.valid <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- configuration

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int value);
    @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_index    <= index;
    cfg_data     <= CFG_DATA_W'(value);
    case (index)
      czc_pkg::REG_CORE_MARGIN:   tile_cfg.core_margin   = COORD_W'(value);
      czc_pkg::REG_IMAGE_WIDTH:   tile_cfg.image_width   = SIDE_W'(value);
      czc_pkg::REG_IMAGE_HEIGHT:  tile_cfg.image_height  = SIDE_W'(value);
      czc_pkg::REG_TILE_ORIGIN_X: tile_cfg.tile_origin_x = COORD_W'(value);
      czc_pkg::REG_TILE_ORIGIN_Y: tile_cfg.tile_origin_y = COORD_W'(value);
      czc_pkg::REG_TILE_WIDTH:    tile_cfg.tile_width    = SIDE_W'(value);
      czc_pkg::REG_TILE_HEIGHT:   tile_cfg.tile_height   = SIDE_W'(value);
      default: ;
    endcase
    // any listed register clears the particle counters
    if (index <= czc_pkg::REG_TILE_HEIGHT) begin
      kept_total      = '0;
      discarded_total = '0;
    end
    @(negedge clk);
    cfg_write_en <= 1'b0;
  endtask

  task automatic program_tile(input int margin, input int iw, input int ih,
                              input int ox, input int oy, input int tw, input int th);
    drain_results();
    write_reg(czc_pkg::REG_CORE_MARGIN, margin);
    write_reg(czc_pkg::REG_IMAGE_WIDTH, iw);
    write_reg(czc_pkg::REG_IMAGE_HEIGHT, ih);
    write_reg(czc_pkg::REG_TILE_ORIGIN_X, ox);
    write_reg(czc_pkg::REG_TILE_ORIGIN_Y, oy);
    write_reg(czc_pkg::REG_TILE_WIDTH, tw);
    write_reg(czc_pkg::REG_TILE_HEIGHT, th);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic void add_point(input int x, input int y, input bit last, input bit none);
    row_t r;
    r.kind         = ROW_POINT;
    r.p.x          = COORD_W'(x);
    r.p.y          = COORD_W'(y);
    r.p.last_point = last;
    r.p.no_points  = none;
    r.index        = '0;
    r.value        = 0;
    r.typed        = 1'b0;
    r.want         = '0;
    stimulus_rows.insert(stimulus_rows.size(), r);
  endfunction

  // point whose decision is spelled out, overflow is never set in this table
  function automatic void add_checked(input int x, input int y, input bit last, input bit none,
                                      input bit keep, input int kept, input int disc);
    add_point(x, y, last, none);
    stimulus_rows[$].typed                = 1'b1;
    stimulus_rows[$].want.keep            = keep;
    stimulus_rows[$].want.kept_count      = REPORT_W'(kept);
    stimulus_rows[$].want.discarded_count = REPORT_W'(disc);
    stimulus_rows[$].want.overflow        = 1'b0;
  endfunction

  function automatic void add_write(input logic [CFG_INDEX_W-1:0] index, input int value);
    row_t r;
    r.kind  = ROW_WRITE;
    r.p     = '0;
    r.index = index;
    r.value = value;
    r.typed = 1'b0;
    r.want  = '0;
    stimulus_rows.insert(stimulus_rows.size(), r);
  endfunction

  function automatic void build_directed();
    // reset setting: whole 1024 x 1024 tile is core
    add_checked(0, 0, 1, 0, 1, 1, 0);
    add_checked(8191, 8191, 1, 0, 0, 1, 1);
    add_checked(1023, 1023, 1, 0, 1, 2, 1);
    add_checked(1024, 0, 1, 0, 0, 2, 2);
    add_checked(0, 1024, 1, 0, 0, 2, 3);
    add_checked(8191, 8191, 1, 1, 1, 3, 3);
    add_point(2000, 0, 0, 0);
    add_point(0, 0, 1, 0);
    // partial contour dropped by a particle without points
    add_point(8191, 8191, 0, 0);
    add_checked(0, 0, 0, 1, 1, 5, 3);
    add_point(5, 5, 1, 0);
    // interior tile, margin on all four sides: core [100, 924)
    add_write(czc_pkg::REG_CORE_MARGIN, 100);
    add_write(czc_pkg::REG_IMAGE_WIDTH, 4000);
    add_write(czc_pkg::REG_IMAGE_HEIGHT, 3000);
    add_write(czc_pkg::REG_TILE_ORIGIN_X, 1000);
    add_write(czc_pkg::REG_TILE_ORIGIN_Y, 1000);
    add_write(czc_pkg::REG_TILE_WIDTH, 1024);
    add_write(czc_pkg::REG_TILE_HEIGHT, 1024);
    add_checked(100, 500, 1, 0, 1, 1, 0);
    add_checked(99, 500, 1, 0, 0, 1, 1);
    add_checked(923, 500, 1, 0, 1, 2, 1);
    add_checked(924, 500, 1, 0, 0, 2, 2);
    add_point(500, 99, 1, 0);
    // left side on the image edge
    add_write(czc_pkg::REG_TILE_ORIGIN_X, 0);
    add_point(0, 500, 1, 0);
    // right side on the image edge
    add_write(czc_pkg::REG_TILE_ORIGIN_X, 2976);
    add_point(1023, 500, 1, 0);
    // margin wider than the tile: whole tile is core
    add_write(czc_pkg::REG_CORE_MARGIN, 8191);
    add_point(0, 0, 1, 0);
    add_point(1023, 1023, 1, 0);
    // empty tile discards everything
    add_write(czc_pkg::REG_TILE_WIDTH, 0);
    add_checked(0, 0, 1, 0, 0, 0, 1);
    // largest sizes and origin
    add_write(czc_pkg::REG_TILE_WIDTH, 8192);
    add_write(czc_pkg::REG_IMAGE_WIDTH, 8192);
    add_write(czc_pkg::REG_TILE_ORIGIN_X, 8191);
    add_write(czc_pkg::REG_CORE_MARGIN, 0);
    add_point(8191, 0, 1, 0);
    // unlisted index leaves counters alone
    add_write(REG_UNLISTED, 16383);
    add_point(0, 0, 1, 0);
  endfunction

  // one random particle: mostly clustered contours near the tile, some noise
  task automatic send_particle(output int sent);
    int     kind;
    int     len;
    int     span_x;
    int     span_y;
    int     cx;
    int     cy;
    int     jit;
    int     off;
    point_t p;
    span_x = (tile_cfg.tile_width == 0) ? 64 : int'(tile_cfg.tile_width) + 32;
    span_y = (tile_cfg.tile_height == 0) ? 64 : int'(tile_cfg.tile_height) + 32;
    if (span_x > COORD_MAX) span_x = COORD_MAX;
    if (span_y > COORD_MAX) span_y = COORD_MAX;
    kind = $urandom_range(0, 15);
    if (kind == 0) begin
      p            = rand_point();
      p.no_points  = 1'b1;
      p.last_point = 1'($urandom_range(0, 1));
      offer_point(p, 1'b0, '0);
      sent = 1;
    end else begin
      len = (kind == 1 || $urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
                                                      : $urandom_range(1, 6);
      cx  = $urandom_range(0, span_x);
      cy  = $urandom_range(0, span_y);
      jit = $urandom_range(0, 6);
      for (int i = 0; i < len; i++) begin
        if (kind == 2) begin
          p = rand_point();
        end else begin
          off = $urandom_range(0, 2 * jit);
          p.x = clip_coord(cx + off - jit);
          off = $urandom_range(0, 2 * jit);
          p.y = clip_coord(cy + off - jit);
        end
        p.last_point = (i == len - 1) && (kind != 1);
        p.no_points  = 1'b0;
        offer_point(p, 1'b0, '0);
      end
      sent = len;
      // broken contour: abandoned by a particle without points
      if (kind == 1) begin
        p            = rand_point();
        p.no_points  = 1'b1;
        p.last_point = 1'($urandom_range(0, 1));
        offer_point(p, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------- watchdog

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- main sequence

  initial begin : main_sequence
    int     sent;
    int     n;
    int     mg;
    int     iw;
    int     ih;
    int     ox;
    int     oy;
    int     tw;
    int     th;

    rst               = 1'b1;
    cfg_write_en      = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    points.valid      = 1'b0;
    points.point_x    = '0;
    points.point_y    = '0;
    points.last_point = 1'b0;
    points.no_points  = 1'b0;
    sender_gaps       = 1'b1;
    receiver_stalls   = 1'b1;
    hold_request      = 1'b0;
    burst_left        = 0;
    typed_row         = 1'b0;
    typed_want        = '0;
    error_count       = 0;

    // predictor reset state
    tile_cfg.core_margin   = '0;
    tile_cfg.image_width   = czc_pkg::MAX_IMAGE_SIDE;
    tile_cfg.image_height  = czc_pkg::MAX_IMAGE_SIDE;
    tile_cfg.tile_origin_x = '0;
    tile_cfg.tile_origin_y = '0;
    tile_cfg.tile_width    = czc_pkg::TILE_SIDE_RESET;
    tile_cfg.tile_height   = czc_pkg::TILE_SIDE_RESET;
    clear_contour();
    kept_total      = '0;
    discarded_total = '0;

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed table
    build_directed();
    foreach (stimulus_rows[i]) begin
      if (stimulus_rows[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(stimulus_rows[i].index, stimulus_rows[i].value);
      end else begin
        offer_point(stimulus_rows[i].p, stimulus_rows[i].typed, stimulus_rows[i].want);
      end
    end

    // random particles over several tile settings, extremes first
    for (int s = 0; s < SETTINGS_RANDOM; s++) begin
      case (s)
        0: program_tile(0, 1, 1, 0, 0, 1, 1);
        1: program_tile(8191, 8192, 8192, 8191, 8191, 8192, 8192);
        2: program_tile(16383, 16383, 16383, 16383, 16383, 16383, 16383);
        default: begin
          mg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 400);
          tw = $urandom_range(0, 1600);
          th = $urandom_range(0, 1600);
          ox = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8191);
          oy = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8191);
          iw = (ox + tw >= 1 && ox + tw <= 8192 && $urandom_range(0, 1) == 0)
               ? ox + tw : $urandom_range(1, 8192);
          ih = (oy + th >= 1 && oy + th <= 8192 && $urandom_range(0, 1) == 0)
               ? oy + th : $urandom_range(1, 8192);
          program_tile(mg, iw, ih, ox, oy, tw, th);
          if ($urandom_range(0, 1) == 0) write_reg(REG_UNLISTED, $urandom_range(0, 16383));
        end
      endcase
      // long receiver hold-off while points keep coming, fills the queue
      if (s == 3) hold_request = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_SETTING) begin
        send_particle(n);
        sent += n;
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/czc_pkg.sv
rtl/core/czc_point_if.sv
rtl/core/czc_result_if.sv
rtl/core/czc_front.sv
rtl/core/czc_queue.sv
rtl/core/czc_back.sv
rtl/core/core_zone_centroid_filter.sv
dv/tb_core_zone_centroid_filter.sv
